// ----- rtl/isi_pkg.sv -----
// Shared types and constants for the IMU sample scale and integrate block.
// No dependencies; every other file in rtl/ imports this package.
package isi_pkg;

  localparam int RAW_W     = 16;
  localparam int RATE_W    = 18;
  localparam int OUT_W     = 19;
  localparam int ANG_W     = 32;
  localparam int TIME_W    = 32;
  localparam int SCALE_W   = 32;
  localparam int FRAC_BITS = 30;
  localparam int MUL_W     = RATE_W + SCALE_W;
  localparam int DIV_DIGIT = 4;
  localparam int PROD_W    = ((MUL_W + DIV_DIGIT - 1) / DIV_DIGIT) * DIV_DIGIT;
  localparam int DIV_STEPS = PROD_W / DIV_DIGIT;
  localparam int STEP_W    = $clog2(DIV_STEPS);
  localparam int REM_W     = 11;
  localparam logic [REM_W:0] DIVISOR = 12'd2000;
  localparam int AXES      = 3;

  localparam logic [31:0] GYRO_SCALE_RST  = 32'd1311823109;
  localparam logic [31:0] ACCEL_SCALE_RST = 32'd2569273713;

  typedef enum logic [1:0] {
    ACT_START = 2'd0,
    ACT_ACCEL = 2'd1,
    ACT_GYRO  = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    REG_GYRO_SCALE  = 2'd0,
    REG_ACCEL_SCALE = 2'd1,
    REG_NEGATE_X    = 2'd2,
    REG_UNUSED      = 2'd3
  } reg_index_t;

  typedef enum logic [1:0] {
    AXIS_X = 2'd0,
    AXIS_Y = 2'd1,
    AXIS_Z = 2'd2,
    AXIS_NONE = 2'd3
  } axis_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic  load;
    logic  stamp;
    logic  scale_mul;
    logic  scale_wr;
    logic  trap_mul;
    logic  div_step;
    logic  trap_acc;
    logic  out_load;
    logic  gyro;
    axis_t axis;
  } cmd_t;

endpackage

// ----- rtl/isi_ctrl.sv -----
// Sequencer for the IMU scale and integrate block: handshakes and datapath commands.
// Depends on isi_pkg.
module isi_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_valid,
  input  logic [1:0]    s_action,
  output logic          s_ready,
  output logic          m_valid,
  input  logic          m_ready,
  output isi_pkg::cmd_t cmd
);
  import isi_pkg::*;

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_SC_MUL = 7'b0000010,
    ST_SC_WR  = 7'b0000100,
    ST_TR_MUL = 7'b0001000,
    ST_TR_DIV = 7'b0010000,
    ST_TR_ACC = 7'b0100000,
    ST_DONE   = 7'b1000000
  } state_t;

  state_t            state, state_next;
  axis_t             axis, axis_next;
  logic [STEP_W-1:0] step, step_next;
  logic              gyro, gyro_next;
  logic              m_valid_next;
  logic              accept;

  assign s_ready = (state == ST_IDLE);
  assign accept  = s_valid && s_ready;

  always_comb begin
    state_next   = state;
    axis_next    = axis;
    step_next    = step;
    gyro_next    = gyro;
    m_valid_next = m_valid && !m_ready;
    cmd          = '0;
    cmd.axis     = axis;
    cmd.gyro     = gyro;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          case (action_t'(s_action))
            ACT_START: cmd.stamp = 1'b1;
            ACT_ACCEL, ACT_GYRO: begin
              cmd.load   = 1'b1;
              // The scale factor is picked on this edge, so the kind of the new request
              // goes out directly rather than through the gyro register.
              cmd.gyro   = (action_t'(s_action) == ACT_GYRO);
              gyro_next  = (action_t'(s_action) == ACT_GYRO);
              axis_next  = AXIS_X;
              state_next = ST_SC_MUL;
            end
            default: ;
          endcase
        end
      end
      ST_SC_MUL: begin
        cmd.scale_mul = 1'b1;
        state_next    = ST_SC_WR;
      end
      ST_SC_WR: begin
        cmd.scale_wr = 1'b1;
        if (axis == AXIS_Z) begin
          axis_next  = AXIS_X;
          state_next = gyro ? ST_TR_MUL : ST_DONE;
        end else begin
          axis_next  = axis_t'(axis + 2'd1);
          state_next = ST_SC_MUL;
        end
      end
      ST_TR_MUL: begin
        cmd.trap_mul = 1'b1;
        step_next    = '0;
        state_next   = ST_TR_DIV;
      end
      ST_TR_DIV: begin
        cmd.div_step = 1'b1;
        if (step == STEP_W'(DIV_STEPS - 1)) begin
          state_next = ST_TR_ACC;
        end else begin
          step_next = step + STEP_W'(1);
        end
      end
      ST_TR_ACC: begin
        cmd.trap_acc = 1'b1;
        if (axis == AXIS_Z) begin
          state_next = ST_DONE;
        end else begin
          axis_next  = axis_t'(axis + 2'd1);
          state_next = ST_TR_MUL;
        end
      end
      ST_DONE: begin
        // The finished result moves into the output register once it is free.
        if (!m_valid || m_ready) begin
          cmd.out_load = 1'b1;
          m_valid_next = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      axis    <= AXIS_X;
      step    <= '0;
      gyro    <= 1'b0;
      m_valid <= 1'b0;
    end else begin
      state   <= state_next;
      axis    <= axis_next;
      step    <= step_next;
      gyro    <= gyro_next;
      m_valid <= m_valid_next;
    end
  end

endmodule

// ----- rtl/isi_datapath.sv -----
// Datapath: shared multiplier, radix-16 divider by 2000, rate and angle state,
// output register. Depends on isi_pkg; driven by isi_ctrl commands.
module isi_datapath (
  input  logic                        clk,
  input  logic                        rst,
  input  isi_pkg::cmd_t               cmd,
  input  logic signed [15:0]          raw_x,
  input  logic signed [15:0]          raw_y,
  input  logic signed [15:0]          raw_z,
  input  logic [31:0]                 time_us,
  input  logic [31:0]                 gyro_scale_q30,
  input  logic [31:0]                 accel_scale_q30,
  input  logic                        negate_x,
  output logic                        kind,
  output logic signed [18:0]          scaled_x,
  output logic signed [18:0]          scaled_y,
  output logic signed [18:0]          scaled_z,
  output logic [31:0]                 angle_x,
  output logic [31:0]                 angle_y,
  output logic [31:0]                 angle_z,
  output logic [31:0]                 stamp_us
);
  import isi_pkg::*;

  // Four restoring steps: brings one hex digit of the dividend into the remainder.
  function automatic logic [DIV_DIGIT+REM_W-1:0] div_digit(input logic [REM_W-1:0] rem_in,
                                                           input logic [DIV_DIGIT-1:0] nib);
    logic [REM_W:0]     r;
    logic [DIV_DIGIT-1:0] q;
    r = {1'b0, rem_in};
    q = '0;
    for (int i = DIV_DIGIT - 1; i >= 0; i--) begin
      r = {r[REM_W-1:0], nib[i]};
      if (r >= DIVISOR) begin
        r    = r - DIVISOR;
        q[i] = 1'b1;
      end
    end
    return {q, r[REM_W-1:0]};
  endfunction

  logic signed [RAW_W-1:0]  raw [AXES];
  logic signed [RATE_W-1:0] scaled [AXES];
  logic signed [RATE_W-1:0] prev_rate [AXES];
  logic [ANG_W-1:0]         acc [AXES];
  logic [TIME_W-1:0]        time_r, dt, prev_time;
  logic [SCALE_W-1:0]       scale_r;
  logic                     negx_r;
  logic [PROD_W-1:0]        prod;
  logic [REM_W-1:0]         rem;
  logic [ANG_W-1:0]         quot;
  logic                     trap_neg;

  logic signed [RAW_W-1:0]  raw_sel;
  logic signed [RAW_W:0]    raw_ext, raw_mag;
  logic signed [OUT_W-1:0]  sum, sum_mag;
  logic [RATE_W-1:0]        mul_a;
  logic [SCALE_W-1:0]       mul_b;
  logic [MUL_W-1:0]         mul_p;
  logic [RATE_W-1:0]        scale_res;
  logic                     scale_neg;
  logic [DIV_DIGIT+REM_W-1:0] div_out;
  logic [ANG_W-1:0]         incr;

  assign raw_sel = raw[cmd.axis];
  assign raw_ext = {raw_sel[RAW_W-1], raw_sel};
  assign raw_mag = raw_sel[RAW_W-1] ? -raw_ext : raw_ext;
  assign sum     = OUT_W'(scaled[cmd.axis]) + OUT_W'(prev_rate[cmd.axis]);
  assign sum_mag = sum[OUT_W-1] ? -sum : sum;

  // One multiplier serves both the scaling and the trapezoid product.
  assign mul_a = cmd.trap_mul ? sum_mag[RATE_W-1:0] : {1'b0, raw_mag[RAW_W:0]};
  assign mul_b = cmd.trap_mul ? dt : scale_r;
  assign mul_p = mul_a * mul_b;

  assign scale_res = prod[FRAC_BITS+RATE_W-1:FRAC_BITS];
  assign scale_neg = raw_sel[RAW_W-1] ^ (negx_r && (cmd.axis == AXIS_X));
  assign div_out   = div_digit(rem, prod[PROD_W-1 -: DIV_DIGIT]);
  assign incr      = trap_neg ? (ANG_W'(0) - quot) : quot;

  // Architectural state: rates, angles and the last gyro time.
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_time <= '0;
      for (int a = 0; a < AXES; a++) begin
        prev_rate[a] <= '0;
        acc[a]       <= '0;
      end
    end else begin
      if (cmd.stamp) prev_time <= time_us;
      if (cmd.out_load && cmd.gyro) prev_time <= time_r;
      if (cmd.trap_acc) begin
        acc[cmd.axis]       <= acc[cmd.axis] + incr;
        prev_rate[cmd.axis] <= scaled[cmd.axis];
      end
    end
  end

  // Working registers and the output register.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      raw[0]  <= raw_x;
      raw[1]  <= raw_y;
      raw[2]  <= raw_z;
      time_r  <= time_us;
      dt      <= time_us - prev_time;
      scale_r <= cmd.gyro ? gyro_scale_q30 : accel_scale_q30;
      negx_r  <= negate_x;
    end
    if (cmd.scale_mul) prod <= PROD_W'(mul_p);
    if (cmd.scale_wr) begin
      scaled[cmd.axis] <= scale_neg ? -$signed(scale_res) : $signed(scale_res);
    end
    if (cmd.trap_mul) begin
      prod     <= PROD_W'(mul_p);
      rem      <= '0;
      quot     <= '0;
      trap_neg <= sum[OUT_W-1];
    end
    if (cmd.div_step) begin
      prod <= prod << DIV_DIGIT;
      rem  <= div_out[REM_W-1:0];
      quot <= {quot[ANG_W-DIV_DIGIT-1:0], div_out[DIV_DIGIT+REM_W-1:REM_W]};
    end
    if (cmd.out_load) begin
      kind     <= cmd.gyro;
      scaled_x <= OUT_W'(scaled[0]);
      scaled_y <= OUT_W'(scaled[1]);
      scaled_z <= OUT_W'(scaled[2]);
      angle_x  <= cmd.gyro ? acc[0] : '0;
      angle_y  <= cmd.gyro ? acc[1] : '0;
      angle_z  <= cmd.gyro ? acc[2] : '0;
      stamp_us <= time_r;
    end
  end

endmodule

// ----- rtl/imu_sample_scale_and_integrate.sv -----
// Top level: stream ports, APB register file, controller and datapath.
// Depends on isi_pkg, isi_ctrl and isi_datapath.
//
//   Channel   Direction  Handshake              Payload
//   s_axis    in         s_axis_tvalid/tready   action, raw x/y/z, time_us
//   m_axis    out        m_axis_tvalid/tready   kind, scaled x/y/z, angles, stamp
//   apb       in         psel/penable/pready    scale factors, negate_x
//
// An accelerometer item runs each axis through the one shared 18x32 multiplier and
// a scaled write before the next accept. A gyroscope item then takes each axis
// through a product, 13 radix-16 divider steps by 2000 and an accumulate.
// A start mark only records the time. Reset is synchronous and clears angles, rates and
// the last gyro time. The result waits in an output register, so a stalled output
// holds the block only when the next result is finished.
module imu_sample_scale_and_integrate (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [79:0]  s_axis_tdata,  // raw_x[15:0], raw_y[31:16], raw_z[47:32], time_us[79:48]
  input  logic [1:0]   s_axis_tuser,  // action[1:0]
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [191:0] m_axis_tdata,  // scaled_x[18:0], scaled_y[37:19], scaled_z[56:38],
                                      // angle_x[88:57], angle_y[120:89], angle_z[152:121],
                                      // stamp_us[184:153], zero[191:185]
  output logic [0:0]   m_axis_tuser,  // kind[0]
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);
  import isi_pkg::*;

  logic [31:0]       gyro_scale_q30, accel_scale_q30;
  logic              negate_x;
  logic              wr_en;
  reg_index_t        reg_idx;
  cmd_t              cmd;
  logic              kind;
  logic signed [18:0] scaled_x, scaled_y, scaled_z;
  logic [31:0]       angle_x, angle_y, angle_z, stamp_us;

  assign pready  = 1'b1;
  assign reg_idx = reg_index_t'(paddr[3:2]);
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      gyro_scale_q30  <= GYRO_SCALE_RST;
      accel_scale_q30 <= ACCEL_SCALE_RST;
      negate_x        <= 1'b1;
    end else if (wr_en) begin
      case (reg_idx)
        REG_GYRO_SCALE:  gyro_scale_q30  <= pwdata;
        REG_ACCEL_SCALE: accel_scale_q30 <= pwdata;
        REG_NEGATE_X:    negate_x        <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_GYRO_SCALE:  prdata = gyro_scale_q30;
      REG_ACCEL_SCALE: prdata = accel_scale_q30;
      REG_NEGATE_X:    prdata = {31'b0, negate_x};
      default:         prdata = '0;
    endcase
  end

  isi_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_valid  (s_axis_tvalid),
    .s_action (s_axis_tuser),
    .s_ready  (s_axis_tready),
    .m_valid  (m_axis_tvalid),
    .m_ready  (m_axis_tready),
    .cmd      (cmd)
  );

  isi_datapath u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .raw_x           (s_axis_tdata[15:0]),
    .raw_y           (s_axis_tdata[31:16]),
    .raw_z           (s_axis_tdata[47:32]),
    .time_us         (s_axis_tdata[79:48]),
    .gyro_scale_q30  (gyro_scale_q30),
    .accel_scale_q30 (accel_scale_q30),
    .negate_x        (negate_x),
    .kind            (kind),
    .scaled_x        (scaled_x),
    .scaled_y        (scaled_y),
    .scaled_z        (scaled_z),
    .angle_x         (angle_x),
    .angle_y         (angle_y),
    .angle_z         (angle_z),
    .stamp_us        (stamp_us)
  );

  assign m_axis_tuser = kind;
  assign m_axis_tdata = {7'b0, stamp_us, angle_z, angle_y, angle_x,
                         scaled_z, scaled_y, scaled_x};

`ifndef NO_ASSERTIONS
  // A start mark gives no result: it cannot raise the output valid.
  a_start_no_result: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready && s_axis_tuser == ACT_START && !m_axis_tvalid)
      |=> !m_axis_tvalid)
    else $error("start mark produced a result");

  // A sample request keeps the block busy in the following cycle.
  a_sample_busy: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready &&
     (s_axis_tuser == ACT_ACCEL || s_axis_tuser == ACT_GYRO)) |=> !s_axis_tready)
    else $error("input accepted while a sample is in progress");

  // Accelerometer results carry zero angles.
  a_accel_zero_angle: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser == 1'b0) |-> (m_axis_tdata[152:57] == '0))
    else $error("accelerometer result with nonzero angle");
`endif

endmodule
